// File: rtl/cvps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvps_pkg
// Widths, payload types and sizing constants for the cell voltage pack
// statistics block.
// ----------------------------------------------------------------------------
package cvps_pkg;

    localparam int MAX_CELLS = 128;

    localparam int CELL_W    = 16;
    localparam int FRAC_W    = 8;
    localparam int TOT_W     = 8;
    localparam int MEAN_W    = 24;
    localparam int STD_W     = 23;

    localparam int CNT_W     = $clog2(MAX_CELLS + 1);
    localparam int SUM_W     = CELL_W + $clog2(MAX_CELLS);
    localparam int SQ_W      = 2 * CELL_W + $clog2(MAX_CELLS);

    // n*sumsq - sum^2, and that value scaled by 2^16
    localparam int DIFF_W    = CNT_W + SQ_W;
    localparam int DIV_W     = DIFF_W + 2 * FRAC_W;
    // sum scaled by 2^8
    localparam int MDIV_W    = SUM_W + FRAC_W;
    localparam int NSQ_W     = 2 * CNT_W;
    localparam int MUL_W     = SQ_W + SUM_W;
    // scaled variance of 16-bit readings stays below 2^(2*STD_W)
    localparam int ROOT_IN_W = 2 * STD_W;
    localparam int REM_W     = STD_W + 3;
    localparam int IT_W      = $clog2(DIV_W + 1);

    typedef struct packed {
        logic [CELL_W-1:0] cell_raw;
        logic              last_cell;
    } t_in;

    typedef struct packed {
        logic [CELL_W-1:0] min_raw;
        logic [CELL_W-1:0] max_raw;
        logic [MEAN_W-1:0] mean_q8;
        logic [STD_W-1:0]  stddev_q8;
        logic [TOT_W-1:0]  cell_total;
    } t_out;

endpackage

// File: rtl/cvps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvps_if
// Valid/ready stream interfaces for cell readings and frame statistics.
// ----------------------------------------------------------------------------
interface cvps_in_if;
    import cvps_pkg::*;

    logic valid;
    logic ready;
    t_in  data;

    modport source (output valid, output data, input  ready);
    modport sink   (input  valid, input  data, output ready);
endinterface

interface cvps_out_if;
    import cvps_pkg::*;

    logic valid;
    logic ready;
    t_out data;

    modport source (output valid, output data, input  ready);
    modport sink   (input  valid, input  data, output ready);
endinterface

// File: rtl/cell_voltage_pack_statistics_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_voltage_pack_statistics_top
// Per-frame min, max, mean and population standard deviation of raw cell
// voltage readings.
// ----------------------------------------------------------------------------
// One reading is taken per transfer; a reading with last_cell set closes the
// frame and produces one statistics transfer. An ordinary reading passes
// through transfer, square and accumulate before the next one is accepted. A
// closing reading then forms n*sumsq, sum^2 and n*n on the multiplier, then
// runs SUM_W+8 = 31 divide steps for the mean, DIFF_W+16 = 63 divide steps
// for the scaled variance and 23 square root steps, all on one shared
// compare/subtract unit, and then loads the output register. One shared
// multiplier forms the squares and the variance products. Readings past
// MAX_CELLS in a frame are dropped from the statistics. The result waits in
// an output register, and a new frame is accepted while it waits.
// ----------------------------------------------------------------------------
module cell_voltage_pack_statistics_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cvps_in_if.sink         i_in,
    cvps_out_if.source      o_out
);
    import cvps_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQR  = 4'd1;
    localparam logic [3:0] S_ACC  = 4'd2;
    localparam logic [3:0] S_MNS  = 4'd3;
    localparam logic [3:0] S_MSS  = 4'd4;
    localparam logic [3:0] S_MNN  = 4'd5;
    localparam logic [3:0] S_DIVM = 4'd6;
    localparam logic [3:0] S_DIVV = 4'd7;
    localparam logic [3:0] S_SQRT = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]        r_state;
    logic              r_ovalid;
    logic [CNT_W-1:0]  r_cnt;
    logic [CELL_W-1:0] r_min;
    logic [CELL_W-1:0] r_max;
    logic [SUM_W-1:0]  r_sum;
    logic [SQ_W-1:0]   r_sumsq;

    logic [CELL_W-1:0] r_cell;
    logic              r_last;
    logic [MUL_W-1:0]  r_prod;
    logic [DIFF_W-1:0] r_nsq;
    logic [NSQ_W-1:0]  r_div;
    logic [DIV_W-1:0]  r_work;
    logic [REM_W-1:0]  r_rem;
    logic [STD_W-1:0]  r_root;
    logic [IT_W-1:0]   r_iter;
    logic [MEAN_W-1:0] r_mean;
    t_out              r_out;

    logic [SQ_W-1:0]   mul_a;
    logic [SUM_W-1:0]  mul_b;
    logic [MUL_W-1:0]  mul_p;

    logic              sqrt_mode;
    logic [REM_W-1:0]  u_cand;
    logic [REM_W-1:0]  u_trial;
    logic              u_ge;
    logic [REM_W-1:0]  n_rem;
    logic [DIV_W-1:0]  n_work;
    logic [STD_W-1:0]  n_root;
    logic              cnt_open;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    assign cnt_open = (r_cnt < CNT_W'(MAX_CELLS));

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQR: begin
                mul_a = SQ_W'(r_cell);
                mul_b = SUM_W'(r_cell);
            end
            S_MNS: begin
                mul_a = r_sumsq;
                mul_b = SUM_W'(r_cnt);
            end
            S_MSS: begin
                mul_a = SQ_W'(r_sum);
                mul_b = r_sum;
            end
            S_MNN: begin
                mul_a = SQ_W'(r_cnt);
                mul_b = SUM_W'(r_cnt);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

    // shared restoring compare/subtract step: divide (1 bit) or root (2 bits)
    assign sqrt_mode = (r_state == S_SQRT);

    always_comb begin
        if (sqrt_mode) begin
            u_cand  = {r_rem[REM_W-3:0], r_work[DIV_W-1 -: 2]};
            u_trial = REM_W'({r_root, 2'b01});
            n_work  = {r_work[DIV_W-3:0], 2'b00};
        end else begin
            u_cand  = {r_rem[REM_W-2:0], r_work[DIV_W-1]};
            u_trial = REM_W'(r_div);
            n_work  = {r_work[DIV_W-2:0], u_cand >= u_trial};
        end
        u_ge   = (u_cand >= u_trial);
        n_rem  = u_ge ? (u_cand - u_trial) : u_cand;
        n_root = {r_root[STD_W-2:0], u_ge};
    end

    // sequencer and frame accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_min    <= '1;
            r_max    <= '0;
            r_sum    <= '0;
            r_sumsq  <= '0;
        end else begin
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (cnt_open) begin
                        r_cnt   <= r_cnt + CNT_W'(1);
                        r_sum   <= r_sum + SUM_W'(r_cell);
                        r_sumsq <= r_sumsq + SQ_W'(r_prod[2*CELL_W-1:0]);
                        if (r_cell < r_min) begin
                            r_min <= r_cell;
                        end
                        if (r_cell > r_max) begin
                            r_max <= r_cell;
                        end
                    end
                    r_state <= r_last ? S_MNS : S_IDLE;
                end
                S_MNS: begin
                    r_state <= S_MSS;
                end
                S_MSS: begin
                    r_state <= S_MNN;
                end
                S_MNN: begin
                    r_state <= S_DIVM;
                end
                S_DIVM: begin
                    if (r_iter == IT_W'(MDIV_W - 1)) begin
                        r_state <= S_DIVV;
                    end
                end
                S_DIVV: begin
                    if (r_iter == IT_W'(DIV_W - 1)) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_iter == IT_W'(STD_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_cnt    <= '0;
                        r_min    <= '1;
                        r_max    <= '0;
                        r_sum    <= '0;
                        r_sumsq  <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    r_cell <= i_in.data.cell_raw;
                    r_last <= i_in.data.last_cell;
                end
            end
            S_SQR: begin
                r_prod <= mul_p;
            end
            S_MNS: begin
                r_nsq <= DIFF_W'(mul_p);
            end
            S_MSS: begin
                r_prod <= mul_p;
            end
            S_MNN: begin
                r_nsq  <= r_nsq - DIFF_W'(r_prod);
                r_prod <= mul_p;
                r_div  <= NSQ_W'(r_cnt);
                r_work <= {r_sum, {(DIV_W - SUM_W){1'b0}}};
                r_rem  <= '0;
                r_iter <= '0;
            end
            S_DIVM: begin
                if (r_iter == IT_W'(MDIV_W - 1)) begin
                    r_mean <= n_work[MEAN_W-1:0];
                    r_work <= {r_nsq, {(2 * FRAC_W){1'b0}}};
                    r_div  <= NSQ_W'(r_prod);
                    r_rem  <= '0;
                    r_iter <= '0;
                end else begin
                    r_iter <= r_iter + IT_W'(1);
                    r_rem  <= n_rem;
                    r_work <= n_work;
                end
            end
            S_DIVV: begin
                if (r_iter == IT_W'(DIV_W - 1)) begin
                    r_work <= {n_work[ROOT_IN_W-1:0], {(DIV_W - ROOT_IN_W){1'b0}}};
                    r_rem  <= '0;
                    r_root <= '0;
                    r_iter <= '0;
                end else begin
                    r_iter <= r_iter + IT_W'(1);
                    r_rem  <= n_rem;
                    r_work <= n_work;
                end
            end
            S_SQRT: begin
                r_iter <= r_iter + IT_W'(1);
                r_rem  <= n_rem;
                r_work <= n_work;
                r_root <= n_root;
            end
            S_DONE: begin
                if (!r_ovalid) begin
                    r_out.min_raw    <= r_min;
                    r_out.max_raw    <= r_max;
                    r_out.mean_q8    <= r_mean;
                    r_out.stddev_q8  <= r_root;
                    r_out.cell_total <= TOT_W'(r_cnt);
                end
            end
            default: begin
                r_iter <= r_iter;
            end
        endcase
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for cell_voltage_pack_statistics_top: directed frames
// from a table, a full frame and an overflow frame, then random pack frames
// of mixed length and spread, with random gaps on the reading side and random
// stalls on the statistics side. Every statistics transfer is checked field
// by field against the table values or a local frame accumulator.
// ----------------------------------------------------------------------------
module tb_top;
    import cvps_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = 150;
    localparam int RANDOM_ITEMS  = 750;
    localparam int QUIET_AFTER   = 650;
    localparam int MAX_REPORTS   = 10;

    typedef enum int {
        FILL_CLUSTER,
        FILL_EXTREME,
        FILL_ANY
    } t_fill;

    typedef struct {
        logic [CELL_W-1:0] raw;
        logic              last;
        bit                typed;
        t_out              stats;
    } t_reading_row;

    typedef struct {
        bit   typed;
        t_out stats;
    } t_typed_stats;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cvps_in_if  readings ();
    cvps_out_if frame_stats ();

    cell_voltage_pack_statistics_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (readings),
        .o_out   (frame_stats)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // frame accumulator
    int                cells_seen;
    logic [CELL_W-1:0] low_raw;
    logic [CELL_W-1:0] high_raw;
    logic [63:0]       raw_sum;
    logic [63:0]       raw_sq_sum;

    t_out          expected_stats [$];
    t_typed_stats  typed_pending [$];
    t_reading_row  directed_rows [$];

    int mismatches = 0;
    int cycles     = 0;
    int sent_items = 0;
    bit quiet      = 1'b0;
    int stall_left = 0;

    function automatic logic [STD_W-1:0] floor_root(input logic [63:0] x);
        logic [31:0] r;
        logic [31:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if (64'(t) * 64'(t) <= x)
                r = t;
        end
        return r[STD_W-1:0];
    endfunction

    function automatic void clear_frame_acc();
        cells_seen = 0;
        low_raw    = '1;
        high_raw   = '0;
        raw_sum    = '0;
        raw_sq_sum = '0;
    endfunction

    function automatic t_out frame_result();
        t_out        s;
        logic [63:0] n;
        logic [63:0] spread;
        n       = 64'(cells_seen);
        spread  = n * raw_sq_sum - raw_sum * raw_sum;
        s.min_raw    = low_raw;
        s.max_raw    = high_raw;
        s.mean_q8    = MEAN_W'((raw_sum << 8) / n);
        s.stddev_q8  = floor_root((spread << 16) / (n * n));
        s.cell_total = TOT_W'(n);
        return s;
    endfunction

    task automatic absorb_reading(input t_in r);
        t_typed_stats ts;
        ts = typed_pending.pop_front();
        if (cells_seen < MAX_CELLS) begin
            cells_seen++;
            if (r.cell_raw < low_raw)
                low_raw = r.cell_raw;
            if (r.cell_raw > high_raw)
                high_raw = r.cell_raw;
            raw_sum    += 64'(r.cell_raw);
            raw_sq_sum += 64'(r.cell_raw) * 64'(r.cell_raw);
        end
        if (r.last_cell) begin
            expected_stats.insert(expected_stats.size(),
                                  ts.typed ? ts.stats : frame_result());
            clear_frame_acc();
        end
    endtask

    task automatic check_stats(input t_out got);
        t_out want;
        if (expected_stats.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: unexpected stats transfer min=%0d max=%0d mean=%0d sd=%0d n=%0d",
                         $realtime, got.min_raw, got.max_raw, got.mean_q8,
                         got.stddev_q8, got.cell_total);
        end else begin
            want = expected_stats.pop_front();
            if (got.min_raw !== want.min_raw || got.max_raw !== want.max_raw ||
                got.mean_q8 !== want.mean_q8 || got.stddev_q8 !== want.stddev_q8 ||
                got.cell_total !== want.cell_total) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: stats mismatch exp min=%0d max=%0d mean=%0d sd=%0d n=%0d",
                             $realtime, want.min_raw, want.max_raw, want.mean_q8,
                             want.stddev_q8, want.cell_total,
                             " got min=%0d max=%0d mean=%0d sd=%0d n=%0d",
                             got.min_raw, got.max_raw, got.mean_q8, got.stddev_q8,
                             got.cell_total);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (frame_stats.valid && frame_stats.ready)
                check_stats(frame_stats.data);
            if (readings.valid && readings.ready)
                absorb_reading(readings.data);
        end
    end

    always @(posedge i_clk) begin
        if (stall_left == 0 && !quiet && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 12);
        if (stall_left != 0) begin
            stall_left--;
            frame_stats.ready <= 1'b0;
        end else begin
            frame_stats.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("cell_voltage_pack_statistics_top test failed");
            $finish;
        end
    end

    task automatic push_reading(input logic [CELL_W-1:0] raw, input logic last,
                                input bit typed, input t_out stats);
        t_typed_stats ts;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            readings.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        ts.typed = typed;
        ts.stats = stats;
        typed_pending.insert(typed_pending.size(), ts);
        readings.valid          <= 1'b1;
        readings.data.cell_raw  <= raw;
        readings.data.last_cell <= last;
        @(posedge i_clk);
        while (!readings.ready) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic add_row(input logic [CELL_W-1:0] raw, input logic last, input bit typed,
                           input int mn, input int mx, input int mean, input int sd,
                           input int n);
        t_reading_row row;
        row.raw              = raw;
        row.last             = last;
        row.typed            = typed;
        row.stats.min_raw    = CELL_W'(mn);
        row.stats.max_raw    = CELL_W'(mx);
        row.stats.mean_q8    = MEAN_W'(mean);
        row.stats.stddev_q8  = STD_W'(sd);
        row.stats.cell_total = TOT_W'(n);
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic send_frame(input int len, input t_fill fill);
        int          base;
        int          spread;
        int          v;
        logic [CELL_W-1:0] raw;
        base   = $urandom_range(0, 65535);
        spread = (1 << $urandom_range(0, 14)) - 1;
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_CLUSTER: begin
                    v   = base + $urandom_range(0, spread);
                    raw = (v > 65535) ? '1 : CELL_W'(v);
                end
                FILL_EXTREME: begin
                    raw = $urandom_range(0, 1) ? '1 : '0;
                    if ($urandom_range(0, 3) == 0)
                        raw = raw ^ CELL_W'($urandom_range(1, 255));
                end
                default: begin
                    raw = CELL_W'($urandom_range(0, 65535));
                end
            endcase
            push_reading(raw, i == len - 1, 1'b0, '0);
        end
    endtask

    initial begin
        int    rand_start;
        int    len;
        t_fill fill;
        t_reading_row row;

        clear_frame_acc();
        i_rst_n           <= 1'b0;
        readings.valid    <= 1'b0;
        readings.data     <= '0;

        // single cells, extreme pairs, mixed patterns, flat frame, small known spread
        add_row(16'h0000, 1'b1, 1'b1, 0, 0, 0, 0, 1);
        add_row(16'hFFFF, 1'b1, 1'b1, 65535, 65535, 16776960, 0, 1);
        add_row(16'h0000, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(16'hFFFF, 1'b1, 1'b1, 0, 65535, 8388480, 8388480, 2);
        add_row(16'hFFFF, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(16'hFFFF, 1'b1, 1'b1, 65535, 65535, 16776960, 0, 2);
        add_row(16'h8000, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(16'h7FFF, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(16'hAAAA, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(16'h5555, 1'b1, 1'b0, 0, 0, 0, 0, 0);
        add_row(16'h1234, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(16'h1234, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(16'h1234, 1'b1, 1'b1, 16'h1234, 16'h1234, 24'h123400, 0, 3);
        add_row(16'h0001, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(16'h0003, 1'b1, 1'b1, 1, 3, 512, 256, 2);
        add_row(16'h0F0F, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(16'hF0F0, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(16'h00FF, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(16'hFF00, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(16'h0001, 1'b1, 1'b0, 0, 0, 0, 0, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            push_reading(row.raw, row.last, row.typed, row.stats);
        end

        rand_start = sent_items;

        // full frame at the top reading: widest sum and sum of squares
        for (int i = 0; i < MAX_CELLS; i++)
            push_reading('1, i == MAX_CELLS - 1, 1'b0, '0);

        // overflow: cells past MAX_CELLS carry extremes that must be dropped,
        // and the closing flag sits on a dropped cell
        for (int i = 0; i < MAX_CELLS + 9; i++)
            push_reading((i < MAX_CELLS) ? CELL_W'($urandom_range(30000, 40000)) :
                         ((i % 2) ? 16'hFFFF : 16'h0000),
                         i == MAX_CELLS + 8, 1'b0, '0);

        while (sent_items - rand_start < RANDOM_ITEMS) begin
            if (sent_items - rand_start >= QUIET_AFTER)
                quiet = 1'b1;
            if ($urandom_range(0, 19) == 0)
                len = $urandom_range(100, MAX_CELLS + 12);
            else
                len = $urandom_range(1, 12);
            fill = t_fill'($urandom_range(0, 2));
            send_frame(len, fill);
        end

        readings.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_stats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_stats.size() == 0) begin
            $display("cell_voltage_pack_statistics_top test passed");
        end else begin
            $display("cell_voltage_pack_statistics_top test failed");
        end
        $finish;
    end

endmodule

// File: cell_voltage_pack_statistics_top.f
rtl/cvps_pkg.sv
rtl/cvps_if.sv
rtl/cell_voltage_pack_statistics_top.sv
dv/tb_top.sv
